FILE: rtl/ddo_pkg.sv
// Shared types, constants and helpers for the wheel odometry block.
// Used by ddo_ctrl, ddo_dp and differential_drive_odometry.
package ddo_pkg;

  localparam int CordicStepsDefault = 24;

  localparam logic [31:0] MptReset = 32'd2199023;
  localparam logic [31:0] IbwReset = 32'd167772160;

  localparam logic [7:0] REG_METERS_PER_TICK    = 8'd0;
  localparam logic [7:0] REG_INVERSE_BASE_WIDTH = 8'd1;

  localparam logic [32:0] TWO_PI_Q24 = 33'd105414357;
  localparam logic signed [27:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [27:0] TWO_PI_Q24_S = 28'sd105414357;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {SH16, SH24, SH30} shift_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] left_count;
    logic [15:0] right_count;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [31:0] heading;
    logic signed [47:0] delta_x;
    logic signed [47:0] delta_y;
    logic signed [31:0] delta_heading;
    logic signed [47:0] left_travel;
    logic signed [47:0] right_travel;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MUL_L, S_MUL_R, S_SUMS, S_DIFF, S_MUL_T, S_RND_T,
    S_ANGLE, S_REM_S, S_FOLD, S_CORDIC, S_MUL_C, S_MUL_S, S_UPDATE,
    S_REM_R, S_REPORT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_CLEAR, CMD_WRAP, CMD_MUL_L, CMD_MUL_R, CMD_SUMS,
    CMD_DIFF, CMD_MUL_T, CMD_RND_T, CMD_ANGLE, CMD_REM, CMD_FOLD, CMD_CORDIC,
    CMD_MUL_C, CMD_MUL_S, CMD_UPDATE, CMD_REPORT
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       zero_ticks;
    logic       ds_zero;
    logic       rem_last;
    logic       cordic_last;
    logic       out_busy;
  } status_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -50'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -67'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [33:0] abs34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

endpackage

FILE: rtl/ddo_ctrl.sv
// Sequencer for the odometry datapath: one command per state.
// Depends on ddo_pkg.
module ddo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ddo_pkg::status_t  status,
  output ddo_pkg::cmd_t     cmd
);

  ddo_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ddo_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ddo_pkg::S_IDLE: if (in_valid) state_next = ddo_pkg::S_DECODE;
      ddo_pkg::S_DECODE: begin
        case (status.op)
          ddo_pkg::OP_SAMPLE:
            state_next = status.zero_ticks ? ddo_pkg::S_IDLE : ddo_pkg::S_MUL_L;
          ddo_pkg::OP_REPORT: state_next = ddo_pkg::S_REM_R;
          default: state_next = ddo_pkg::S_IDLE;
        endcase
      end
      ddo_pkg::S_MUL_L: state_next = ddo_pkg::S_MUL_R;
      ddo_pkg::S_MUL_R: state_next = ddo_pkg::S_SUMS;
      ddo_pkg::S_SUMS:  state_next = ddo_pkg::S_DIFF;
      ddo_pkg::S_DIFF:  state_next = ddo_pkg::S_MUL_T;
      ddo_pkg::S_MUL_T: state_next = ddo_pkg::S_RND_T;
      ddo_pkg::S_RND_T:
        state_next = status.ds_zero ? ddo_pkg::S_UPDATE : ddo_pkg::S_ANGLE;
      ddo_pkg::S_ANGLE: state_next = ddo_pkg::S_REM_S;
      ddo_pkg::S_REM_S: if (status.rem_last) state_next = ddo_pkg::S_FOLD;
      ddo_pkg::S_FOLD:  state_next = ddo_pkg::S_CORDIC;
      ddo_pkg::S_CORDIC: if (status.cordic_last) state_next = ddo_pkg::S_MUL_C;
      ddo_pkg::S_MUL_C: state_next = ddo_pkg::S_MUL_S;
      ddo_pkg::S_MUL_S: state_next = ddo_pkg::S_UPDATE;
      ddo_pkg::S_UPDATE: state_next = ddo_pkg::S_IDLE;
      ddo_pkg::S_REM_R: if (status.rem_last) state_next = ddo_pkg::S_REPORT;
      ddo_pkg::S_REPORT: if (!status.out_busy) state_next = ddo_pkg::S_IDLE;
      default: state_next = ddo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = ddo_pkg::CMD_NONE;
    in_ready = 1'b0;
    case (state)
      ddo_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = ddo_pkg::CMD_LOAD;
      end
      ddo_pkg::S_DECODE: begin
        case (status.op)
          ddo_pkg::OP_REPORT: cmd = ddo_pkg::CMD_WRAP;
          ddo_pkg::OP_CLEAR:  cmd = ddo_pkg::CMD_CLEAR;
          default: cmd = ddo_pkg::CMD_NONE;
        endcase
      end
      ddo_pkg::S_MUL_L:  cmd = ddo_pkg::CMD_MUL_L;
      ddo_pkg::S_MUL_R:  cmd = ddo_pkg::CMD_MUL_R;
      ddo_pkg::S_SUMS:   cmd = ddo_pkg::CMD_SUMS;
      ddo_pkg::S_DIFF:   cmd = ddo_pkg::CMD_DIFF;
      ddo_pkg::S_MUL_T:  cmd = ddo_pkg::CMD_MUL_T;
      ddo_pkg::S_RND_T:  cmd = ddo_pkg::CMD_RND_T;
      ddo_pkg::S_ANGLE:  cmd = ddo_pkg::CMD_ANGLE;
      ddo_pkg::S_REM_S:  cmd = ddo_pkg::CMD_REM;
      ddo_pkg::S_FOLD:   cmd = ddo_pkg::CMD_FOLD;
      ddo_pkg::S_CORDIC: cmd = ddo_pkg::CMD_CORDIC;
      ddo_pkg::S_MUL_C:  cmd = ddo_pkg::CMD_MUL_C;
      ddo_pkg::S_MUL_S:  cmd = ddo_pkg::CMD_MUL_S;
      ddo_pkg::S_UPDATE: cmd = ddo_pkg::CMD_UPDATE;
      ddo_pkg::S_REM_R:  cmd = ddo_pkg::CMD_REM;
      ddo_pkg::S_REPORT: if (!status.out_busy) cmd = ddo_pkg::CMD_REPORT;
      default: cmd = ddo_pkg::CMD_NONE;
    endcase
  end

endmodule

FILE: rtl/ddo_dp.sv
// Odometry datapath: shared multiplier, remainder-by-2pi unit, CORDIC,
// pose state, config registers and output word register. Depends on ddo_pkg.
module ddo_dp #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ddo_pkg::cmd_t        cmd,
  output ddo_pkg::status_t     status,
  input  ddo_pkg::in_word_t    in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ddo_pkg::out_word_t   out_data
);

  localparam int IW = $clog2(CORDIC_STEPS);

  logic [31:0] mpt, ibw;

  logic [1:0] op_q;
  logic signed [16:0] lt, rt;
  logic signed [31:0] dl, dr, ds, dt;
  logic signed [32:0] diff;
  logic signed [35:0] dx;

  // multiplier: magnitudes in, sign and rounding shift kept alongside
  logic [33:0] ma;
  logic [31:0] mb;
  logic        msign, psign;
  ddo_pkg::shift_t msh, psh;
  logic [65:0] p, q;
  logic signed [66:0] rnd;

  logic        rem_neg;
  logic [32:0] rem_mag;
  logic [2:0]  rem_k;
  logic signed [33:0] rem_val;

  logic signed [33:0] cx, cy, cz;
  logic        cneg;
  logic [IW-1:0] cidx;

  logic signed [47:0] x_acc, y_acc, x_at, y_at, left_sum, right_sum;
  logic signed [31:0] theta_acc, theta_at;

  logic signed [16:0] lt_in, rt_in;
  logic signed [32:0] angle, sum_lr;
  logic signed [27:0] r0, r1;
  logic signed [33:0] z0, xs, ys;
  logic [32:0] rem_sub;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mpt <= ddo_pkg::MptReset;
      ibw <= ddo_pkg::IbwReset;
    end else if (cfg_valid) begin
      if (cfg_index == ddo_pkg::REG_METERS_PER_TICK) mpt <= cfg_data;
      else if (cfg_index == ddo_pkg::REG_INVERSE_BASE_WIDTH) ibw <= cfg_data;
    end
  end

  // negative reads get one added
  assign lt_in = $signed({in_data.left_count[15], in_data.left_count})
                 + 17'(in_data.left_count[15]);
  assign rt_in = $signed({in_data.right_count[15], in_data.right_count})
                 + 17'(in_data.right_count[15]);

  always_comb begin
    case (psh)
      ddo_pkg::SH16: q = (p >> 16) + 66'(p[15]);
      ddo_pkg::SH24: q = (p >> 24) + 66'(p[23]);
      default:       q = (p >> 30) + 66'(p[29]);
    endcase
    rnd = psign ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  assign sum_lr = 33'(dl) + 33'(dr);
  assign angle = 33'(theta_acc) + 33'(dt >>> 1);
  assign rem_sub = ddo_pkg::TWO_PI_Q24 << rem_k;
  assign rem_val = rem_neg ? -$signed({1'b0, rem_mag}) : $signed({1'b0, rem_mag});

  // bring the remainder into [-pi, pi], then to Q2.30
  always_comb begin
    r0 = rem_val[27:0];
    if (r0 > ddo_pkg::PI_Q24) r1 = r0 - ddo_pkg::TWO_PI_Q24_S;
    else if (r0 < -ddo_pkg::PI_Q24) r1 = r0 + ddo_pkg::TWO_PI_Q24_S;
    else r1 = r0;
    z0 = 34'(r1) <<< 6;
  end

  assign xs = cx >>> cidx;
  assign ys = cy >>> cidx;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    msign = 1'b0;
    msh = ddo_pkg::SH16;
    case (cmd)
      ddo_pkg::CMD_MUL_L: begin
        ma = ddo_pkg::abs34(34'(lt));
        mb = mpt;
        msign = lt[16];
      end
      ddo_pkg::CMD_MUL_R: begin
        ma = ddo_pkg::abs34(34'(rt));
        mb = mpt;
        msign = rt[16];
      end
      ddo_pkg::CMD_MUL_T: begin
        ma = ddo_pkg::abs34(34'(diff));
        mb = ibw;
        msign = diff[32];
        msh = ddo_pkg::SH24;
      end
      ddo_pkg::CMD_MUL_C: begin
        ma = ddo_pkg::abs34(34'(ds));
        mb = 32'(ddo_pkg::abs34(cx));
        msign = ds[31] ^ cx[33] ^ cneg;
        msh = ddo_pkg::SH30;
      end
      ddo_pkg::CMD_MUL_S: begin
        ma = ddo_pkg::abs34(34'(ds));
        mb = 32'(ddo_pkg::abs34(cy));
        msign = ds[31] ^ cy[33] ^ cneg;
        msh = ddo_pkg::SH30;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    psign <= msign;
    psh <= msh;
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ddo_pkg::CMD_LOAD: begin
        op_q <= in_data.op;
        lt <= lt_in;
        rt <= rt_in;
      end
      ddo_pkg::CMD_MUL_R: dl <= rnd[31:0];
      ddo_pkg::CMD_SUMS:  dr <= rnd[31:0];
      ddo_pkg::CMD_DIFF: begin
        diff <= 33'(dl) - 33'(dr);
        ds <= 32'((sum_lr + 33'(sum_lr[32])) >>> 1);
      end
      ddo_pkg::CMD_RND_T: dt <= ddo_pkg::sat32(rnd);
      ddo_pkg::CMD_ANGLE: begin
        rem_neg <= angle[32];
        rem_mag <= 33'(ddo_pkg::abs34(34'(angle)));
        rem_k <= 3'd5;
      end
      ddo_pkg::CMD_WRAP: begin
        rem_neg <= theta_acc[31];
        rem_mag <= 33'(ddo_pkg::abs34(34'(theta_acc)));
        rem_k <= 3'd5;
      end
      ddo_pkg::CMD_REM: begin
        if (rem_mag >= rem_sub) rem_mag <= rem_mag - rem_sub;
        rem_k <= rem_k - 3'd1;
      end
      ddo_pkg::CMD_FOLD: begin
        cx <= ddo_pkg::CORDIC_GAIN;
        cy <= '0;
        cidx <= '0;
        if (z0 > ddo_pkg::HALF_PI_Q30) begin
          cz <= z0 - ddo_pkg::PI_Q30;
          cneg <= 1'b1;
        end else if (z0 < -ddo_pkg::HALF_PI_Q30) begin
          cz <= z0 + ddo_pkg::PI_Q30;
          cneg <= 1'b1;
        end else begin
          cz <= z0;
          cneg <= 1'b0;
        end
      end
      ddo_pkg::CMD_CORDIC: begin
        if (!cz[33]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - 34'(ddo_pkg::atan_q30(5'(cidx)));
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + 34'(ddo_pkg::atan_q30(5'(cidx)));
        end
        cidx <= cidx + 1'b1;
      end
      ddo_pkg::CMD_MUL_S: dx <= rnd[35:0];
      default: ;
    endcase
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst || cmd == ddo_pkg::CMD_CLEAR) begin
      x_acc <= '0;
      y_acc <= '0;
      theta_acc <= '0;
      x_at <= '0;
      y_at <= '0;
      theta_at <= '0;
      left_sum <= '0;
      right_sum <= '0;
    end else if (cmd == ddo_pkg::CMD_UPDATE) begin
      if (ds != 32'sd0) begin
        x_acc <= ddo_pkg::sat48(50'(x_acc) + 50'(dx));
        y_acc <= ddo_pkg::sat48(50'(y_acc) + 50'($signed(rnd[35:0])));
      end
      theta_acc <= ddo_pkg::sat32(67'(theta_acc) + 67'(dt));
      left_sum <= ddo_pkg::sat48(50'(left_sum) + 50'(dl));
      right_sum <= ddo_pkg::sat48(50'(right_sum) + 50'(dr));
    end else if (cmd == ddo_pkg::CMD_REPORT) begin
      theta_acc <= rem_val[31:0];
      theta_at <= rem_val[31:0];
      x_at <= x_acc;
      y_at <= y_acc;
      left_sum <= '0;
      right_sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd == ddo_pkg::CMD_REPORT) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd == ddo_pkg::CMD_REPORT) begin
      out_data.pos_x <= x_acc;
      out_data.pos_y <= y_acc;
      out_data.heading <= rem_val[31:0];
      out_data.delta_x <= ddo_pkg::sat48(50'(x_acc) - 50'(x_at));
      out_data.delta_y <= ddo_pkg::sat48(50'(y_acc) - 50'(y_at));
      out_data.delta_heading <= ddo_pkg::sat32(67'(theta_acc) - 67'(theta_at));
      out_data.left_travel <= left_sum;
      out_data.right_travel <= right_sum;
    end
  end

  assign status.op = op_q;
  assign status.zero_ticks = (lt == 17'sd0) && (rt == 17'sd0);
  assign status.ds_zero = (sum_lr == 33'sd1) || (sum_lr == -33'sd1) ||
                          (sum_lr == 33'sd0);
  assign status.rem_last = (rem_k == 3'd0);
  assign status.cordic_last = (cidx == IW'(CORDIC_STEPS - 1));
  assign status.out_busy = out_valid && !out_ready;

endmodule

FILE: rtl/differential_drive_odometry.sv
// Wheel odometry top level: a sample runs through shared multiplier steps, a
// 6-step 2pi remainder and the CORDIC loop; a sample with zero mean travel
// skips the CORDIC. A report waits for out_ready while the last word is held;
// its word is registered. One item is in work at a time.
// Synchronous reset zeroes the pose and sums and loads register defaults.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ddo_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ddo_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  ddo_pkg::cmd_t    cmd;
  ddo_pkg::status_t status;

  ddo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .status(status), .cmd(cmd)
  );

  ddo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
